/* rtl/assert_macros.svh */
// Assertion macros used by the top-level RTL file of the sorted merge block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Antecedent implies consequent in the same cycle.
`define KWM_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("kwm assertion failed");

// Antecedent implies consequent in the following cycle.
`define KWM_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("kwm assertion failed");

`else

`define KWM_ASSERT_IMP(label, clk, rstn, ante, cons)
`define KWM_ASSERT_NXT(label, clk, rstn, ante, cons)

`endif

`endif

/* rtl/kwm_pkg.sv */
// Shared command codes and stream field widths of the sorted merge block.
package kwm_pkg;

    localparam int CMD_W      = 2;
    localparam int LIST_ID_W  = 3;
    localparam int IO_VALUE_W = 32;

    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    // list_id + value, rounded up to whole bytes
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = CMD_W;
    // out_value + source_list, rounded up to whole bytes
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 2;

endpackage

/* rtl/kwm_elem_mem.sv */
// Element store: one write port and one registered read port.
module kwm_elem_mem #(
    parameter int ADDR_W = 9,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/kwm_min_tree.sv */
// Comparator tree picking the smallest valid head; ties go to the higher list.
module kwm_min_tree #(
    parameter int NUM_LISTS   = 8,
    parameter int VALUE_WIDTH = 32,
    parameter int LW          = 3
) (
    input  logic signed [VALUE_WIDTH-1:0] head [NUM_LISTS],
    input  logic [NUM_LISTS-1:0]          present,
    output logic                          found,
    output logic [LW-1:0]                 best_idx
);

    localparam int P = 1 << LW;

    logic                          node_vld [1:2*P-1];
    logic signed [VALUE_WIDTH-1:0] node_key [1:2*P-1];
    logic [LW-1:0]                 node_idx [1:2*P-1];

    genvar i;
    generate
        for (i = 0; i < P; i++)
        begin : g_leaf
            if (i < NUM_LISTS)
            begin : g_used
                assign node_vld[P+i] = present[i];
                assign node_key[P+i] = head[i];
            end
            else
            begin : g_pad
                assign node_vld[P+i] = 1'b0;
                assign node_key[P+i] = '0;
            end
            assign node_idx[P+i] = LW'(i);
        end

        for (i = 1; i < P; i++)
        begin : g_node
            logic take_hi;
            // upper child wins on equal keys
            assign take_hi = node_vld[2*i+1] &&
                             (!node_vld[2*i] || (node_key[2*i+1] <= node_key[2*i]));
            assign node_vld[i] = node_vld[2*i] || node_vld[2*i+1];
            assign node_key[i] = take_hi ? node_key[2*i+1] : node_key[2*i];
            assign node_idx[i] = take_hi ? node_idx[2*i+1] : node_idx[2*i];
        end
    endgenerate

    assign found    = node_vld[1];
    assign best_idx = node_idx[1];

endmodule

/* rtl/k_way_sorted_merge.sv */
// Top level of the k-way sorted merge: per-list queues, head registers, sequencer.
`include "assert_macros.svh"
// Flow: an accepted transfer is captured in the input register and executes from there once
//   the result register is free; a waiting result holds the item back.
// Append, clear, the unused command and a pop that finds nothing or empties its list let the
//   next item in as they execute; a pop that leaves its list non-empty holds the input back
//   until the registered read of the element memory is refilling that list's head register.
// Reset (rst_n low, asynchronous): pointers, fill counts, sequencer and output valid clear;
//   the element memory is not cleared, as only written entries are ever read.
module k_way_sorted_merge #(
    parameter int NUM_LISTS   = 8,
    parameter int LIST_DEPTH  = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // list_id [2:0], value [34:3], zero [39:35]
    input  logic [kwm_pkg::S_TDATA_W-1:0]  s_tdata,
    // command [1:0]
    input  logic [kwm_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // out_value [31:0], source_list [34:32], zero [39:35]
    output logic [kwm_pkg::M_TDATA_W-1:0]  m_tdata,
    // valid_res [0], overflow [1]
    output logic [kwm_pkg::M_TUSER_W-1:0]  m_tuser
);

    import kwm_pkg::*;

    localparam int LW = $clog2(NUM_LISTS);
    localparam int PW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int AW = LW + PW;

    // sequencer codes
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_FILL = 2'd2;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(LIST_DEPTH - 1)) ? '0 : PW'(p + 1'b1);
    endfunction

    // input register
    logic [CMD_W-1:0]              cmd_reg;
    logic [LIST_ID_W-1:0]          lid_reg;
    logic signed [VALUE_WIDTH-1:0] val_reg;

    logic [1:0]                    state_reg, state_next;
    logic [LW-1:0]                 fill_list_reg;

    // per-list queue state
    logic [PW-1:0]                 rptr_reg [NUM_LISTS];
    logic [PW-1:0]                 wptr_reg [NUM_LISTS];
    logic [CW-1:0]                 cnt_reg  [NUM_LISTS];
    logic signed [VALUE_WIDTH-1:0] head_reg [NUM_LISTS];
    logic [NUM_LISTS-1:0]          present;

    // result register
    logic                          m_valid_reg;
    logic [IO_VALUE_W-1:0]         m_value_reg;
    logic [LIST_ID_W-1:0]          m_src_reg;
    logic                          m_vres_reg;
    logic                          m_ovf_reg;

    logic                          found;
    logic [LW-1:0]                 best;
    logic signed [VALUE_WIDTH-1:0] best_head;
    logic [PW-1:0]                 best_rptr_next;
    logic [LW-1:0]                 lid_idx;
    logic                          lid_ok;
    logic                          list_full;
    logic                          go;
    logic                          is_pop;
    logic                          is_append;
    logic                          do_pop;
    logic                          do_write;
    logic                          need_fill;
    logic                          s_acc;
    logic [VALUE_WIDTH-1:0]        mem_rd_data;

    genvar g;
    generate
        for (g = 0; g < NUM_LISTS; g++)
        begin : g_present
            assign present[g] = (cnt_reg[g] != '0);
        end
    endgenerate

    kwm_min_tree #(
        .NUM_LISTS   (NUM_LISTS),
        .VALUE_WIDTH (VALUE_WIDTH),
        .LW          (LW)
    ) u_min_tree (
        .head     (head_reg),
        .present  (present),
        .found    (found),
        .best_idx (best)
    );

    assign best_head      = head_reg[best];
    assign best_rptr_next = ptr_inc(rptr_reg[best]);
    assign lid_idx        = LW'(lid_reg);
    assign lid_ok         = (int'(lid_reg) < NUM_LISTS);
    assign list_full      = (cnt_reg[lid_idx] == CW'(LIST_DEPTH));

    // the item in the input register executes once the result register is free
    assign go        = (state_reg == S_EXEC) && (!m_valid_reg || m_tready);
    assign is_pop    = (cmd_reg == CMD_POP);
    assign is_append = (cmd_reg == CMD_APPEND);
    assign do_pop    = go && is_pop && found;
    assign do_write  = go && is_append && lid_ok && !list_full;
    // a pop that leaves elements behind refills its head from memory next cycle
    assign need_fill = is_pop && found && (cnt_reg[best] > CW'(1));

    assign s_tready = (state_reg == S_IDLE) || (state_reg == S_FILL) || (go && !need_fill);
    assign s_acc    = s_tvalid && s_tready;

    kwm_elem_mem #(
        .ADDR_W (AW),
        .DATA_W (VALUE_WIDTH)
    ) u_elem_mem (
        .clk     (clk),
        .wr_en   (do_write),
        .wr_addr ({lid_idx, wptr_reg[lid_idx]}),
        .wr_data (val_reg),
        .rd_en   (do_pop && need_fill),
        .rd_addr ({best, best_rptr_next}),
        .rd_data (mem_rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_acc)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (go)
                begin
                    if (need_fill)
                    begin
                        state_next = S_FILL;
                    end
                    else if (!s_acc)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_FILL:
            begin
                state_next = s_acc ? S_EXEC : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // capture the accepted transfer; the value is held at VALUE_WIDTH bits
    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            cmd_reg <= s_tuser[CMD_W-1:0];
            lid_reg <= s_tdata[LIST_ID_W-1:0];
            val_reg <= VALUE_WIDTH'($signed(s_tdata[LIST_ID_W +: IO_VALUE_W]));
        end
    end

    // pointers and fill counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < NUM_LISTS; l++)
            begin
                rptr_reg[l] <= '0;
                wptr_reg[l] <= '0;
                cnt_reg[l]  <= '0;
            end
        end
        else if (go && (cmd_reg == CMD_CLEAR))
        begin
            for (int l = 0; l < NUM_LISTS; l++)
            begin
                rptr_reg[l] <= '0;
                wptr_reg[l] <= '0;
                cnt_reg[l]  <= '0;
            end
        end
        else if (do_write)
        begin
            wptr_reg[lid_idx] <= ptr_inc(wptr_reg[lid_idx]);
            cnt_reg[lid_idx]  <= CW'(cnt_reg[lid_idx] + 1'b1);
        end
        else if (do_pop)
        begin
            rptr_reg[best] <= best_rptr_next;
            cnt_reg[best]  <= CW'(cnt_reg[best] - 1'b1);
        end
    end

    // head registers: load directly on append to an empty list, else from memory
    always_ff @(posedge clk)
    begin
        if (do_write && (cnt_reg[lid_idx] == '0))
        begin
            head_reg[lid_idx] <= val_reg;
        end
        else if (state_reg == S_FILL)
        begin
            head_reg[fill_list_reg] <= mem_rd_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_pop)
        begin
            fill_list_reg <= best;
        end
    end

    // result register: hold until taken, load when the item executes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (go)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            m_value_reg <= do_pop ? IO_VALUE_W'(best_head) : '0;
            m_src_reg   <= do_pop ? LIST_ID_W'(best) : '0;
            m_vres_reg  <= is_pop && found;
            m_ovf_reg   <= is_append && lid_ok && list_full;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({m_src_reg, m_value_reg});
    assign m_tuser  = {m_ovf_reg, m_vres_reg};

    // a refill always follows the pop that asked for it
    `KWM_ASSERT_NXT(a_fill_after_pop, clk, rst_n, go && need_fill, state_reg == S_FILL)
    // an accepted transfer is always in the execute state in the next cycle
    `KWM_ASSERT_NXT(a_exec_after_accept, clk, rst_n, s_acc, state_reg == S_EXEC)
    // a result never reports both a popped element and a dropped append
    `KWM_ASSERT_IMP(a_flags_exclusive, clk, rst_n, m_valid_reg, !(m_vres_reg && m_ovf_reg))
    // nothing is accepted while the result register is blocked
    `KWM_ASSERT_IMP(a_no_accept_blocked, clk, rst_n, (state_reg == S_EXEC) && m_valid_reg && !m_tready, !s_tready)

endmodule

/* verif/k_way_sorted_merge_tb.sv */
// Self-checking testbench for the k-way sorted merge: random streams against a queue model.
module k_way_sorted_merge_tb;

    import kwm_pkg::*;

    localparam int NUM_LISTS  = 8;
    localparam int LIST_DEPTH = 64;

    // The fourth command code does nothing; the package leaves it unnamed.
    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

    localparam int RANDOM_ITEMS  = 850;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int LONG_HOLD     = 400;
    localparam int HOLD_AFTER    = 150;
    localparam int DRAIN_CYCLES  = 8;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  src;
        logic        found;
        logic        ovf;
    } merge_result_t;

    // Queue model of the merge: one bounded queue per list, results in transfer order.
    class merge_scoreboard;
        logic [31:0]   lists [NUM_LISTS][$];
        merge_result_t pending [$];
        int failures, checked, hits, empty_pops, overflows, clears, ties, noops;

        function int stored();
            int total = 0;
            for (int l = 0; l < NUM_LISTS; l++)
                total += lists[l].size();
            return total;
        endfunction

        // Work out the result of one accepted input transfer.
        function void note_transfer(logic [CMD_W-1:0] cmd, logic [2:0] id, logic [31:0] val);
            merge_result_t res;
            bit found;
            int best;
            res = '0;
            found = 0;
            best = 0;
            case (cmd)
                CMD_APPEND:
                begin
                    if (lists[id].size() >= LIST_DEPTH)
                    begin
                        res.ovf = 1'b1;
                        overflows++;
                    end
                    else
                        lists[id].push_back(val);
                end
                CMD_POP:
                begin
                    // Equal heads go to the higher-numbered list, hence <=.
                    for (int l = 0; l < NUM_LISTS; l++)
                    begin
                        if (lists[l].size() != 0)
                        begin
                            if (found && lists[l][0] == lists[best][0])
                                ties++;
                            if (!found || $signed(lists[l][0]) <= $signed(lists[best][0]))
                            begin
                                found = 1;
                                best = l;
                            end
                        end
                    end
                    if (found)
                    begin
                        res.value = lists[best].pop_front();
                        res.src   = best[2:0];
                        res.found = 1'b1;
                        hits++;
                    end
                    else
                        empty_pops++;
                end
                CMD_CLEAR:
                begin
                    for (int l = 0; l < NUM_LISTS; l++)
                        lists[l].delete();
                    clears++;
                end
                default:
                    noops++;
            endcase
            pending.push_back(res);
        endfunction

        // Compare one accepted output transfer with the oldest outstanding result.
        function void check_result(logic [M_TDATA_W-1:0] tdata, logic [M_TUSER_W-1:0] tuser);
            merge_result_t got, want;
            got.value = tdata[31:0];
            got.src   = tdata[34:32];
            got.found = tuser[0];
            got.ovf   = tuser[1];
            checked++;
            if (pending.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected result: value=%h src=%0d valid=%b ovf=%b",
                             got.value, got.src, got.found, got.ovf);
                return;
            end
            want = pending.pop_front();
            if (got.value !== want.value || got.src !== want.src ||
                got.found !== want.found || got.ovf !== want.ovf)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display({"mismatch on result %0d: expected value=%h src=%0d valid=%b ",
                              "ovf=%b, got value=%h src=%0d valid=%b ovf=%b"},
                             checked, want.value, want.src, want.found, want.ovf,
                             got.value, got.src, got.found, got.ovf);
            end
        endfunction
    endclass

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic [S_TUSER_W-1:0]  s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;

    merge_scoreboard sb = new();

    bit tx_steady;          // sender runs without gaps during this stretch
    bit long_hold_done;
    int fed;                // input transfers that do something

    k_way_sorted_merge #(
        .NUM_LISTS   (NUM_LISTS),
        .LIST_DEPTH  (LIST_DEPTH),
        .VALUE_WIDTH (32)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Hold reset at the start, then release it for good.
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Idle length: mostly none or short, now and then a long one.
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Offer one item and hold it until the transfer completes. Valid stays high
    // between back-to-back items so it is never dropped and raised in one step.
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [2:0] id,
                             input logic [31:0] val);
        int gap;
        gap = tx_steady ? 0 : idle_cycles();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, val, id};
        s_tuser  <= cmd;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_transfer(cmd, id, val);
        if (cmd != CMD_NOP)
            fed++;
    endtask

    // Receiver: random back-pressure, runs of steady acceptance, and one long
    // hold-off so the block fills up and pushes back on its input.
    initial
    begin
        int hold;
        int run_left;
        run_left = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!long_hold_done && sb.checked >= HOLD_AFTER)
            begin
                hold = LONG_HOLD;
                long_hold_done = 1;
            end
            else if (run_left > 0)
            begin
                hold = 0;
                run_left--;
            end
            else
            begin
                hold = idle_cycles();
                if ($urandom_range(0, 9) == 0)
                    run_left = $urandom_range(20, 80);
            end
            if (hold > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
        end
    end

    // Check every output transfer; values are sampled as they stood before the edge.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    // Give up after a generous number of cycles.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles, %0d results outstanding",
                 CYCLE_LIMIT, sb.pending.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // Stimulus: directed corner cases, then random episodes.
    initial
    begin
        logic [31:0] tail [NUM_LISTS];
        logic [31:0] base;
        int          ep;
        int          n;
        int          r;
        logic [2:0]  l;

        wait (rst_n === 1'b1);
        @(posedge clk);

        // Pop on empty lists and the unused command.
        send_item(CMD_POP, 3'd0, 32'h0);
        send_item(CMD_NOP, 3'd7, 32'hFFFF_FFFF);
        // Extreme values, then equal heads on three lists; pop them all and one more.
        send_item(CMD_APPEND, 3'd0, 32'h7FFF_FFFF);
        send_item(CMD_APPEND, 3'd7, 32'h8000_0000);
        send_item(CMD_APPEND, 3'd3, 32'hFFFF_FFFF);
        send_item(CMD_APPEND, 3'd5, 32'h0000_0000);
        send_item(CMD_APPEND, 3'd2, 32'd5);
        send_item(CMD_APPEND, 3'd6, 32'd5);
        send_item(CMD_APPEND, 3'd4, 32'd5);
        repeat (8) send_item(CMD_POP, 3'd7, 32'hFFFF_FFFF);
        // Clear with data held, then pop nothing.
        send_item(CMD_APPEND, 3'd1, 32'hAAAA_AAAA);
        send_item(CMD_APPEND, 3'd1, 32'h5555_5555);
        send_item(CMD_CLEAR, 3'd0, 32'h0);
        send_item(CMD_POP, 3'd0, 32'h0);
        // Same list refilled after a clear starts from its first entry again.
        send_item(CMD_APPEND, 3'd1, 32'h1234_5678);
        send_item(CMD_POP, 3'd0, 32'h0);
        send_item(CMD_CLEAR, 3'd5, 32'hFFFF_FFFF);

        fed = 0;
        ep = 0;
        while (fed < RANDOM_ITEMS)
        begin
            tx_steady = ($urandom_range(0, 3) == 0);
            // Open with a fill to capacity so a dropped append is seen early.
            r = (ep == 0) ? 58 : $urandom_range(0, 99);
            ep++;
            if (r < 55)
            begin
                // Sorted runs on random lists from a shared base, so heads often tie.
                case ($urandom_range(0, 3))
                    0:       base = 32'h8000_0000 + $urandom_range(0, 20);
                    1:       base = 32'h7FFF_FFC0;
                    default: base = $urandom;
                endcase
                for (int i = 0; i < NUM_LISTS; i++)
                    tail[i] = base;
                n = $urandom_range(4, 40);
                for (int i = 0; i < n; i++)
                begin
                    if ($urandom_range(0, 99) < 70)
                    begin
                        l = 3'($urandom_range(0, NUM_LISTS - 1));
                        tail[l] = tail[l] + $urandom_range(0, 3);
                        send_item(CMD_APPEND, l, tail[l]);
                    end
                    else
                        send_item(CMD_POP, 3'($urandom), $urandom);
                end
                while (sb.stored() != 0)
                    send_item(CMD_POP, 3'($urandom), $urandom);
                send_item(CMD_POP, 3'($urandom), $urandom);
            end
            else if (r < 65)
            begin
                // Fill one list to capacity, push past it, then clear or drain.
                l = 3'($urandom_range(0, NUM_LISTS - 1));
                base = $urandom;
                while (sb.lists[l].size() < LIST_DEPTH)
                begin
                    base = base + $urandom_range(0, 1000);
                    send_item(CMD_APPEND, l, base);
                end
                repeat ($urandom_range(1, 3)) send_item(CMD_APPEND, l, $urandom);
                if ($urandom_range(0, 1) == 0)
                    send_item(CMD_CLEAR, 3'($urandom), $urandom);
                else
                    while (sb.stored() != 0)
                        send_item(CMD_POP, 3'($urandom), $urandom);
            end
            else if (r < 90)
            begin
                // Noise: any command, any list, any value.
                repeat ($urandom_range(5, 30))
                begin
                    n = $urandom_range(0, 99);
                    if (n < 45)
                        send_item(CMD_APPEND, 3'($urandom), $urandom);
                    else if (n < 85)
                        send_item(CMD_POP, 3'($urandom), $urandom);
                    else if (n < 90)
                        send_item(CMD_CLEAR, 3'($urandom), $urandom);
                    else
                        send_item(CMD_NOP, 3'($urandom), $urandom);
                end
            end
            else
                send_item(CMD_CLEAR, 3'($urandom), $urandom);
        end
        s_tvalid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d results: %0d pops with data (%0d equal-head ties),",
                 sb.checked, sb.hits, sb.ties);
        $display("%0d empty pops, %0d dropped appends, %0d clears, %0d idle commands; %0d mismatches.",
                 sb.empty_pops, sb.overflows, sb.clears, sb.noops, sb.failures);
        if (sb.failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* k_way_sorted_merge.f */
+incdir+rtl
rtl/kwm_pkg.sv
rtl/kwm_elem_mem.sv
rtl/kwm_min_tree.sv
rtl/k_way_sorted_merge.sv
verif/k_way_sorted_merge_tb.sv
